// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

// implication checked on the same clock edge
`define ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

`endif

// File: hw/rtl/rmh_pkg.sv
// shared constants, types and helpers of the running median block
package rmh_pkg;

    localparam int VALUE_BITS = 31;
    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = CNT_W + 1;
    localparam int TOTAL_W    = CNT_W + 1;

    // heap select codes
    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef logic [VALUE_BITS-1:0] value_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;
        logic op_begin;
        logic op_push;
        logic op_sel;
        logic op_from_carry;
        logic up_check;
        logic up_cmp;
        logic dn_check;
        logic dn_left;
        logic dn_cmp;
        logic finish;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic even;
        logic lower_empty;
        logic full;
        logic v_lt_ltop;
        logic v_gt_utop;
        logic idx_root;
        logic up_moved;
        logic no_left;
        logic dn_moved;
    } dp_status_t;

    // true when a belongs above b in the selected heap
    function automatic logic goes_above(input value_t a, input value_t b, input logic sel);
        goes_above = (sel == HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

endpackage

// File: hw/rtl/running_median_two_heaps.sv
// Running median over all accepted words, kept in a max-heap (lower half) and a
// min-heap (upper half), each in its own ram. One word is taken at a time; an
// item with the store full goes straight to its result; any other runs the
// heap sift loops, check and compare per level sifting up, check, left read
// and compare per level down; at most one sift down and one sift up per item.
// A result still waiting for m_tready holds the next item in its last cycle.
// Once 1024 words are stored, further words are dropped and flagged in tuser.
module running_median_two_heaps (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] median_value
    output logic        m_tuser    // [0] dropped
);

    rmh_pkg::dp_cmd_t    cmd;
    rmh_pkg::dp_status_t status;
    rmh_pkg::value_t     median;
    logic                dropped;

    rmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmh_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_tdata[rmh_pkg::VALUE_BITS-1:0]),
        .status  (status),
        .median  (median),
        .dropped (dropped)
    );

    // output packing
    assign m_tdata = {{(32 - rmh_pkg::VALUE_BITS){1'b0}}, median};
    assign m_tuser = dropped;

endmodule

// File: hw/rtl/rmh_ram.sv
// generic single-write, single-read ram with registered read
module rmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rmh_datapath.sv
// heap stores, counts, sift registers and result register
module rmh_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rmh_pkg::dp_cmd_t       cmd,
    input  rmh_pkg::value_t        sample,
    output rmh_pkg::dp_status_t    status,
    output rmh_pkg::value_t        median,
    output logic                   dropped
);

    logic [rmh_pkg::CNT_W-1:0]   lcnt_reg, ucnt_reg;
    rmh_pkg::value_t             v_reg, val_reg, carry_reg, lc_reg;
    rmh_pkg::value_t             ltop_reg, utop_reg, median_reg;
    logic                        drop_reg, out_drop_reg, sel_reg, r_ok_reg;
    logic [rmh_pkg::CNT_W-1:0]   idx_reg;

    logic [rmh_pkg::CNT_W-1:0]   cnt_sel, cnt_op;
    logic [rmh_pkg::TOTAL_W-1:0] total;
    logic [rmh_pkg::IDX_W-1:0]   left_i, right_i;
    rmh_pkg::value_t             rd_lo, rd_up, rdata, top_sel;
    rmh_pkg::value_t             child_v, wdata;
    logic [rmh_pkg::CNT_W-1:0]   child_i;
    logic                        pick_r, up_moved, dn_moved, no_left;
    logic                        we, we_lo, we_up;
    logic [rmh_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [rmh_pkg::VALUE_BITS:0] pair_sum;

    // selected heap views
    assign cnt_sel = (sel_reg == rmh_pkg::HEAP_LOWER) ? lcnt_reg : ucnt_reg;
    assign cnt_op  = (cmd.op_sel == rmh_pkg::HEAP_LOWER) ? lcnt_reg : ucnt_reg;
    assign top_sel = (cmd.op_sel == rmh_pkg::HEAP_LOWER) ? ltop_reg : utop_reg;
    assign rdata   = (sel_reg == rmh_pkg::HEAP_LOWER) ? rd_lo : rd_up;
    assign total   = rmh_pkg::TOTAL_W'(lcnt_reg) + rmh_pkg::TOTAL_W'(ucnt_reg);

    // child indices of the hole
    assign left_i  = {idx_reg, 1'b0};
    assign right_i = {idx_reg, 1'b1};
    assign no_left = left_i > rmh_pkg::IDX_W'(cnt_sel);

    // compares for sift up and sift down
    assign up_moved = rmh_pkg::goes_above(val_reg, rdata, sel_reg);
    assign pick_r   = r_ok_reg && rmh_pkg::goes_above(rdata, lc_reg, sel_reg);
    assign child_v  = pick_r ? rdata : lc_reg;
    assign child_i  = pick_r ? right_i[rmh_pkg::CNT_W-1:0] : left_i[rmh_pkg::CNT_W-1:0];
    assign dn_moved = rmh_pkg::goes_above(child_v, val_reg, sel_reg);

    // ram write and read selection
    always_comb begin
        we    = 1'b0;
        wdata = val_reg;
        raddr = '0;
        if (cmd.up_check) begin
            we    = (idx_reg == rmh_pkg::CNT_W'(1));
            raddr = rmh_pkg::ADDR_W'((idx_reg >> 1) - rmh_pkg::CNT_W'(1));
        end else if (cmd.up_cmp) begin
            we    = 1'b1;
            wdata = up_moved ? rdata : val_reg;
        end else if (cmd.dn_check) begin
            we    = no_left;
            raddr = rmh_pkg::ADDR_W'(left_i - rmh_pkg::IDX_W'(1));
        end else if (cmd.dn_left) begin
            raddr = rmh_pkg::ADDR_W'(right_i - rmh_pkg::IDX_W'(1));
        end else if (cmd.dn_cmp) begin
            we    = 1'b1;
            wdata = dn_moved ? child_v : val_reg;
        end
    end

    assign waddr = rmh_pkg::ADDR_W'(idx_reg - rmh_pkg::CNT_W'(1));
    assign we_lo = we && (sel_reg == rmh_pkg::HEAP_LOWER);
    assign we_up = we && (sel_reg == rmh_pkg::HEAP_UPPER);

    rmh_ram #(.WIDTH(rmh_pkg::VALUE_BITS), .DEPTH(rmh_pkg::HEAP_DEPTH)) u_lower_ram (
        .aclk  (aclk),
        .we    (we_lo),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_lo)
    );

    rmh_ram #(.WIDTH(rmh_pkg::VALUE_BITS), .DEPTH(rmh_pkg::HEAP_DEPTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (we_up),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_up)
    );

    // heap counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg <= '0;
            ucnt_reg <= '0;
        end else if (cmd.op_begin && cmd.op_push) begin
            if (cmd.op_sel == rmh_pkg::HEAP_LOWER) begin
                lcnt_reg <= lcnt_reg + rmh_pkg::CNT_W'(1);
            end else begin
                ucnt_reg <= ucnt_reg + rmh_pkg::CNT_W'(1);
            end
        end
    end

    // sift registers and shadow tops
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            v_reg    <= sample;
            drop_reg <= total >= rmh_pkg::TOTAL_W'(rmh_pkg::CAPACITY);
        end
        if (cmd.op_begin) begin
            sel_reg <= cmd.op_sel;
            if (cmd.op_push) begin
                val_reg <= cmd.op_from_carry ? carry_reg : v_reg;
                idx_reg <= cnt_op + rmh_pkg::CNT_W'(1);
            end else begin
                val_reg   <= v_reg;
                carry_reg <= top_sel;
                idx_reg   <= rmh_pkg::CNT_W'(1);
            end
        end
        if (cmd.up_cmp && up_moved) begin
            idx_reg <= idx_reg >> 1;
        end
        if (cmd.dn_left) begin
            lc_reg   <= rdata;
            r_ok_reg <= right_i <= rmh_pkg::IDX_W'(cnt_sel);
        end
        if (cmd.dn_cmp && dn_moved) begin
            idx_reg <= child_i;
        end
        if (we && (waddr == '0)) begin
            if (sel_reg == rmh_pkg::HEAP_LOWER) begin
                ltop_reg <= wdata;
            end else begin
                utop_reg <= wdata;
            end
        end
        // result word is loaded only when the previous one has gone
        if (cmd.finish) begin
            median_reg   <= (lcnt_reg != ucnt_reg) ? utop_reg
                                                   : pair_sum[rmh_pkg::VALUE_BITS:1];
            out_drop_reg <= drop_reg;
        end
    end

    // sum of both tops for the even case
    assign pair_sum = {1'b0, ltop_reg} + {1'b0, utop_reg};

    // status back to the controller
    assign status.even        = (lcnt_reg == ucnt_reg);
    assign status.lower_empty = (lcnt_reg == '0);
    assign status.full        = drop_reg;
    assign status.v_lt_ltop   = v_reg < ltop_reg;
    assign status.v_gt_utop   = v_reg > utop_reg;
    assign status.idx_root    = (idx_reg == rmh_pkg::CNT_W'(1));
    assign status.up_moved    = up_moved;
    assign status.no_left     = no_left;
    assign status.dn_moved    = dn_moved;

    assign median  = median_reg;
    assign dropped = out_drop_reg;

endmodule

// File: hw/rtl/rmh_ctrl.sv
// controller that sequences heap inserts and output handshake
module rmh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  rmh_pkg::dp_status_t status,
    output rmh_pkg::dp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECIDE  = 4'd1;
    localparam logic [3:0] ST_UP_CHK  = 4'd2;
    localparam logic [3:0] ST_UP_CMP  = 4'd3;
    localparam logic [3:0] ST_DN_CHK  = 4'd4;
    localparam logic [3:0] ST_DN_LEFT = 4'd5;
    localparam logic [3:0] ST_DN_CMP  = 4'd6;
    localparam logic [3:0] ST_NEXT    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       pend_sel_reg, pend_sel_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       op_end_state;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign op_end_state = pend_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        pend_sel_next = pend_sel_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.full) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op_begin = 1'b1;
                    if (status.even) begin
                        if (!status.lower_empty && status.v_lt_ltop) begin
                            cmd.op_sel    = rmh_pkg::HEAP_LOWER;
                            pend_next     = 1'b1;
                            pend_sel_next = rmh_pkg::HEAP_UPPER;
                            state_next    = ST_DN_CHK;
                        end else begin
                            cmd.op_push = 1'b1;
                            cmd.op_sel  = rmh_pkg::HEAP_UPPER;
                            state_next  = ST_UP_CHK;
                        end
                    end else begin
                        if (status.v_gt_utop) begin
                            cmd.op_sel    = rmh_pkg::HEAP_UPPER;
                            pend_next     = 1'b1;
                            pend_sel_next = rmh_pkg::HEAP_LOWER;
                            state_next    = ST_DN_CHK;
                        end else begin
                            cmd.op_push = 1'b1;
                            cmd.op_sel  = rmh_pkg::HEAP_LOWER;
                            state_next  = ST_UP_CHK;
                        end
                    end
                end
            end
            ST_UP_CHK: begin
                cmd.up_check = 1'b1;
                if (status.idx_root) begin
                    state_next = op_end_state ? ST_NEXT : ST_DONE;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                cmd.up_cmp = 1'b1;
                if (status.up_moved) begin
                    state_next = ST_UP_CHK;
                end else begin
                    state_next = op_end_state ? ST_NEXT : ST_DONE;
                end
            end
            ST_DN_CHK: begin
                cmd.dn_check = 1'b1;
                if (status.no_left) begin
                    state_next = op_end_state ? ST_NEXT : ST_DONE;
                end else begin
                    state_next = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT: begin
                cmd.dn_left = 1'b1;
                state_next  = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                cmd.dn_cmp = 1'b1;
                if (status.dn_moved) begin
                    state_next = ST_DN_CHK;
                end else begin
                    state_next = op_end_state ? ST_NEXT : ST_DONE;
                end
            end
            ST_NEXT: begin
                // carried top goes into the other heap
                cmd.op_begin      = 1'b1;
                cmd.op_push       = 1'b1;
                cmd.op_sel        = pend_sel_reg;
                cmd.op_from_carry = 1'b1;
                pend_next         = 1'b0;
                state_next        = ST_UP_CHK;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            pend_sel_reg <= rmh_pkg::HEAP_LOWER;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            pend_sel_reg <= pend_sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: hw/rtl/rmh_checker.sv
// port-level checker for the running median block, bound to the top level
`include "assert_macros.svh"

module rmh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    logic in_word;
    assign in_word = s_tvalid && s_tready && (s_tdata[31] || !s_tdata[31]);

    // reset clears the result valid
    `ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)
    // one word at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_word, !s_tready)
    // a stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // a stalled result keeps its data and flag
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // padding bit of the result word stays zero
    `ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, !m_tdata[31])

endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/running_median_two_heaps_test.sv
// testbench for the running median block: stream driver, monitor and sorted-list predictor
`timescale 1ns / 100ps

module running_median_two_heaps_test;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int STORE_CAP    = 1024;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    running_median_two_heaps dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    typedef struct packed {
        rmh_pkg::value_t median;
        logic            dropped;
    } median_word_t;

    // pending words and expected medians
    rmh_pkg::value_t sample_queue[$];
    median_word_t    median_queue[$];

    // predictor state: sorted copy of stored values
    rmh_pkg::value_t stored_vals[$];

    int  error_count = 0;
    int  result_count = 0;
    int  drop_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 28;
    int  recv_idle_pct = 67;
    bit  recv_hold = 1'b0;
    bit  stimulus_done = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    // insert into the sorted set unless it is full and compute the median it yields
    function automatic median_word_t predict_median(input rmh_pkg::value_t v);
        median_word_t r;
        int           n;
        int           pos;
        logic [31:0]  sum;
        r.dropped = 1'b0;
        if (stored_vals.size() >= STORE_CAP) begin
            r.dropped = 1'b1;
        end else begin
            pos = 0;
            while (pos < stored_vals.size() && stored_vals[pos] < v) pos++;
            stored_vals.insert(pos, v);
        end
        n = stored_vals.size();
        if (n % 2 == 1) begin
            r.median = stored_vals[n / 2];
        end else begin
            sum = {1'b0, stored_vals[n / 2 - 1]} + {1'b0, stored_vals[n / 2]};
            r.median = sum[31:1];
        end
        return r;
    endfunction

    // driver: offer words from the queue, keep valid high across back-to-back words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, sample_queue.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready generation
    always @(posedge aclk) begin
        if (aresetn)
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on each accepted input word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            median_queue.push_back(predict_median(s_tdata[30:0]));
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        median_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (median_queue.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 32'h0);
            end else begin
                want = median_queue.pop_front();
                if (m_tdata[30:0] !== want.median)
                    report_mismatch("median_value", m_tdata, {1'b0, want.median});
                if (m_tuser !== want.dropped)
                    report_mismatch("dropped", {31'h0, m_tuser}, {31'h0, want.dropped});
                if (want.dropped) drop_count++;
            end
            result_count++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        recv_hold = 1'b1;
        repeat (600) @(posedge aclk);
        recv_hold = 1'b0;
    end

    task automatic wait_drained();
        while (sample_queue.size() > 0 || s_tvalid || median_queue.size() > 0)
            @(posedge aclk);
    endtask

    function automatic rmh_pkg::value_t random_sample();
        case ($urandom_range(5))
            0: return rmh_pkg::value_t'($urandom_range(15));
            1: return {4'hF, 27'($urandom)};
            2: return rmh_pkg::value_t'(31'h7FFF_FFF0 + $urandom_range(15));
            default: return rmh_pkg::value_t'($urandom);
        endcase
    endfunction

    initial begin
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, duplicates, ascending and descending runs
        sample_queue.push_back(31'h7FFF_FFFF);
        sample_queue.push_back(31'h0);
        sample_queue.push_back(31'h7FFF_FFFF);
        sample_queue.push_back(31'h7FFF_FFFE);
        sample_queue.push_back(31'h5555_5555);
        sample_queue.push_back(31'h2AAA_AAAA);
        for (k = 0; k < 6; k++) sample_queue.push_back(31'd100);
        for (k = 0; k < 6; k++) sample_queue.push_back(rmh_pkg::value_t'(k * 3));
        for (k = 0; k < 6; k++) sample_queue.push_back(rmh_pkg::value_t'(31'h7000_0000 - k));

        // random, through the three idling phases
        for (k = 0; k < 400; k++) sample_queue.push_back(random_sample());
        wait_drained();
        send_idle_pct = 67;
        recv_idle_pct = 28;
        for (k = 0; k < 400; k++) sample_queue.push_back(random_sample());
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // overflow the store so the full case is hit repeatedly
        for (k = 0; k < 300; k++) sample_queue.push_back(random_sample());
        wait_drained();
        repeat (100) @(posedge aclk);

        $display("ran %0d result words, %0d flagged as dropped, store held %0d values",
                 result_count, drop_count, stored_vals.size());
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_ram.sv
hw/rtl/rmh_datapath.sv
hw/rtl/rmh_ctrl.sv
hw/rtl/running_median_two_heaps.sv
hw/rtl/rmh_checker.sv
test/running_median_two_heaps_test.sv
